@@ src/assert_macros.svh @@
// Assertion macros used by the checker file mf3_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MF3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mf3 assertion failed");

// Next-cycle implication checked on every edge, reset included.
`define MF3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mf3 assertion failed");

`endif

@@ src/mf3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mf3_pkg;

    localparam int PIX_W         = 8;
    localparam int ROW_W         = 12;
    localparam int COL_W         = 10;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RST_WIDTH     = 1024;
    localparam int RST_HEIGHT    = 1024;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int OUT_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // One median request: 3x3 window snapshot, in-frame mask and tags
    typedef struct packed {
        t_pix [8:0]       vals;
        logic [8:0]       mask;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_job;

endpackage
`default_nettype wire

@@ src/mf3_line_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mf3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/mf3_window.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mf3_window #(
    parameter int MAX_WIDTH = 1024,
    parameter int CNT_W     = 10,
    parameter int CMP_W     = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_acc,
    input  wire mf3_pkg::t_pix                i_pixel,
    input  wire logic [CNT_W-1:0]             i_col,
    input  wire logic [mf3_pkg::ROW_W-1:0]    i_row,
    input  wire logic                         i_lastc,
    input  wire logic                         i_lastr,
    input  wire logic [CMP_W-1:0]             i_w_eff,
    input  wire logic [mf3_pkg::FH_W-1:0]     i_h_eff,
    output logic                              o_ready,
    output logic                              o_job_valid,
    input  wire logic                         i_job_ready,
    output mf3_pkg::t_job                     o_job
);
    import mf3_pkg::*;

    localparam int DW = 2 * PIX_W;

    // item waiting for its row buffer data
    logic             r_v2;
    t_pix             r_p;
    logic [CNT_W-1:0] r_c;
    logic [ROW_W-1:0] r_r;
    logic             r_lastc, r_lastr;
    logic             r_fwd;
    logic [DW-1:0]    r_fwd_data;

    // window and result sequencer
    t_pix [2:0][2:0]  r_win, n_win;
    t_pix [8:0]       r_snap;
    logic [3:0]       r_pend, n_pend;
    logic [CNT_W-1:0] r3_c;
    logic [ROW_W-1:0] r3_r;

    logic [DW-1:0] mem_rdata, cur_rd, wdata;
    t_pix          rd_a, rd_b;
    logic          s2_fire, s3_valid, s3_free, issue;

    mf3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CNT_W),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s2_fire),
        .i_waddr (r_c),
        .i_wdata (wdata),
        .i_re    (i_acc),
        .i_raddr (i_col),
        .o_rdata (mem_rdata)
    );

    // forward the write that landed on the same edge as this read
    assign cur_rd = r_fwd ? r_fwd_data : mem_rdata;
    assign rd_a   = cur_rd[DW-1:PIX_W];
    assign rd_b   = cur_rd[PIX_W-1:0];
    assign wdata  = {rd_b, r_p};

    assign s3_valid = |r_pend;
    assign s3_free  = !s3_valid || (i_job_ready && $onehot(r_pend));
    assign s2_fire  = r_v2 && s3_free;
    assign o_ready  = !r_v2 || s3_free;
    assign issue    = s3_valid && i_job_ready;

    // window shift with the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = rd_a;
        n_win[1][2] = rd_b;
        n_win[2][2] = r_p;
    end

    // pending results: lowest bit goes first
    always_comb begin
        n_pend = r_pend;
        if (issue) begin
            n_pend = r_pend & (r_pend - 4'd1);
        end
        if (s2_fire) begin
            n_pend = {r_lastr && r_lastc,
                      r_lastr && (r_c != '0),
                      (r_r != '0) && r_lastc,
                      (r_r != '0) && (r_c != '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_fwd  <= 1'b0;
            r_win  <= '0;
            r_pend <= '0;
        end else begin
            if (i_acc) begin
                r_v2  <= 1'b1;
                r_fwd <= s2_fire && (r_c == i_col);
            end else if (s2_fire) begin
                r_v2 <= 1'b0;
            end
            if (s2_fire) begin
                r_win <= n_win;
            end
            r_pend <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_p        <= i_pixel;
            r_c        <= i_col;
            r_r        <= i_row;
            r_lastc    <= i_lastc;
            r_lastr    <= i_lastr;
            r_fwd_data <= wdata;
        end
        if (s2_fire) begin
            r3_c <= r_c;
            r3_r <= r_r;
            for (int k = 0; k < 9; k++) begin
                r_snap[k] <= n_win[k / 3][k % 3];
            end
        end
    end

    // neighbour mask and tags of the result being issued
    logic             up, left;
    logic [ROW_W-1:0] ii;
    logic [CNT_W-1:0] jj;
    logic [2:0]       rin, cin, rok, cok;
    logic [FH_W-1:0]  ii_x;
    logic [CMP_W-1:0] jj_x;

    always_comb begin
        // kinds: (r-1,c-1), (r-1,c), (r,c-1), (r,c); lowest pending bit wins
        up   = r_pend[0] || r_pend[1];
        left = r_pend[0] || (!r_pend[1] && r_pend[2]);
        ii   = up ? r3_r - ROW_W'(1) : r3_r;
        jj   = left ? r3_c - CNT_W'(1) : r3_c;
        ii_x = FH_W'(ii);
        jj_x = CMP_W'(jj);
        rin[0] = (ii != '0) && (ii_x <= i_h_eff);
        rin[1] = ii_x < i_h_eff;
        rin[2] = (ii_x + FH_W'(1)) < i_h_eff;
        cin[0] = (jj != '0) && (jj_x <= i_w_eff);
        cin[1] = jj_x < i_w_eff;
        cin[2] = (jj_x + CMP_W'(1)) < i_w_eff;
        // center at window row/col 1 when up/left, else 2
        rok = up ? rin : {rin[1], rin[0], 1'b0};
        cok = left ? cin : {cin[1], cin[0], 1'b0};
        for (int k = 0; k < 9; k++) begin
            o_job.mask[k] = rok[k / 3] && cok[k % 3];
        end
        o_job.vals = r_snap;
        o_job.row  = ii;
        o_job.col  = COL_W'(jj);
        o_job.last = r_pend[3] && !(|r_pend[2:0]);
    end

    assign o_job_valid = s3_valid;

endmodule
`default_nettype wire

@@ src/mf3_median.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mf3_median (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_valid,
    output logic                           o_job_ready,
    input  wire mf3_pkg::t_job             i_job,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output mf3_pkg::t_pix                  o_med,
    output logic [mf3_pkg::ROW_W-1:0]      o_row,
    output logic [mf3_pkg::COL_W-1:0]      o_col,
    output logic                           o_last
);
    import mf3_pkg::*;

    logic             r1_v, r2_v, r_ov;
    t_job             r1_job;
    t_pix             r2_lo, r2_hi, r_med;
    logic [ROW_W-1:0] r2_row, r_row;
    logic [COL_W-1:0] r2_col, r_col;
    logic             r2_last, r_last;
    logic             out_free, m2_free, m1_free;

    assign out_free    = !r_ov || i_ready;
    assign m2_free     = !r2_v || out_free;
    assign m1_free     = !r1_v || m2_free;
    assign o_job_ready = m1_free;

    // rank of each masked value, ties broken by position
    logic [3:0]       rank [9];
    logic [3:0]       cnt, half, lo_rank;
    t_pix             lo, hi;
    logic [PIX_W:0]   sum;

    always_comb begin
        cnt = '0;
        for (int k = 0; k < 9; k++) begin
            cnt = cnt + 4'(r1_job.mask[k]);
        end
        for (int i = 0; i < 9; i++) begin
            rank[i] = '0;
            for (int j = 0; j < 9; j++) begin
                if (j != i && r1_job.mask[j] &&
                    (r1_job.vals[j] < r1_job.vals[i] ||
                     (r1_job.vals[j] == r1_job.vals[i] && j < i))) begin
                    rank[i] = rank[i] + 4'd1;
                end
            end
        end
        half    = cnt >> 1;
        lo_rank = cnt[0] ? half : half - 4'd1;
        lo = '0;
        hi = '0;
        for (int i = 0; i < 9; i++) begin
            if (r1_job.mask[i] && rank[i] == half) begin
                hi = hi | r1_job.vals[i];
            end
            if (r1_job.mask[i] && rank[i] == lo_rank) begin
                lo = lo | r1_job.vals[i];
            end
        end
    end

    assign sum = {1'b0, r2_lo} + {1'b0, r2_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (m1_free) begin
                r1_v <= i_job_valid;
            end
            if (m2_free) begin
                r2_v <= r1_v;
            end
            if (out_free) begin
                r_ov <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m1_free) begin
            r1_job <= i_job;
        end
        if (m2_free) begin
            r2_lo   <= lo;
            r2_hi   <= hi;
            r2_row  <= r1_job.row;
            r2_col  <= r1_job.col;
            r2_last <= r1_job.last;
        end
        if (out_free) begin
            r_med  <= sum[PIX_W:1];
            r_row  <= r2_row;
            r_col  <= r2_col;
            r_last <= r2_last;
        end
    end

    assign o_valid = r_ov;
    assign o_med   = r_med;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_last  = r_last;

endmodule
`default_nettype wire

@@ src/median_filter_3x3_shrinking_edges.sv @@
// 3x3 median filter over a raster pixel stream; at the frame edges only the
// in-frame neighbours count, and an even count gives the floor of the mean of
// the two middle values. Frame width and height are set through the write port
// (index 0 width, 1 height); the user must do so only while the block is idle,
// which the block itself does not enforce. Each result carries its row and
// column; tlast marks the final result of a frame. A pixel yields up to four
// results, one per clock from the single median unit unless the output stalls;
// a pixel waits for the last result of the one before. Two row buffers sit in
// one synchronous memory read and written once per pixel. A pixel reaches the
// output through the window and median registers. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_3x3_shrinking_edges #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // pixel
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // median_value[7:0], out_row[19:8], out_col[29:20], zero pad
    output logic [mf3_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                    m_axis_tlast,  // frame_last
    input  wire logic                               i_cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mf3_pkg::*;

    localparam int CNT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = ((FW_W > WEFF_W) ? FW_W : WEFF_W) + 1;
    localparam int PAD_W  = OUT_DATA_W - PIX_W - ROW_W - COL_W;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [CNT_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CMP_W-1:0] w_eff, fw_x;
    logic [FH_W-1:0]  h_eff;
    logic             lastc, lastr, acc, win_ready;
    logic             job_valid, job_ready;
    t_job             job;
    t_pix             med;
    logic [ROW_W-1:0] o_row;
    logic [COL_W-1:0] o_col;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(RST_WIDTH);
            r_frame_height <= FH_W'(RST_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp frame size to the supported range
    always_comb begin
        fw_x = CMP_W'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (fw_x > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_x;
        end
        if (r_frame_height == '0) begin
            h_eff = FH_W'(1);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign lastc = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
    assign lastr = (FH_W'(r_row) + FH_W'(1)) >= h_eff;
    assign acc   = s_axis_tvalid && win_ready;

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .CNT_W     (CNT_W),
        .CMP_W     (CMP_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_pixel     (s_axis_tdata[PIX_W-1:0]),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_lastc     (lastc),
        .i_lastr     (lastr),
        .i_w_eff     (w_eff),
        .i_h_eff     (h_eff),
        .o_ready     (win_ready),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    mf3_median u_median (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_med       (med),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_last      (m_axis_tlast)
    );

    assign s_axis_tready = win_ready;
    assign m_axis_tdata  = {PAD_W'(0), o_col, o_row, med};

endmodule
`default_nettype wire

@@ src/mf3_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mf3_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [mf3_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           m_axis_tlast
);

    logic out_stall;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result keeps its payload
    `MF3_ASSERT_NXT(a_out_hold, i_rst_n && out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // reset empties the result pipeline
    `MF3_ASSERT_NXT(a_rst_empty, !i_rst_n, !m_axis_tvalid)
    // after reset the input side is open
    `MF3_ASSERT_NXT(a_rst_ready, !i_rst_n, s_axis_tready)
    // pad bits above the column field stay zero
    `MF3_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:30] == 2'b00)

endmodule

bind median_filter_3x3_shrinking_edges mf3_checker u_mf3_checker (.*);
`default_nettype wire

@@ test/median_filter_3x3_shrinking_edges_tb.sv @@
`timescale 1ns / 1ps
module median_filter_3x3_shrinking_edges_tb;
    import mf3_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int BUF_DEPTH      = 1024;

    typedef struct {
        logic [7:0]       med;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_median_res;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    median_filter_3x3_shrinking_edges u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow filter state
    logic [7:0]       line_older [BUF_DEPTH];
    logic [7:0]       line_newer [BUF_DEPTH];
    logic [7:0]       win [3][3];
    int unsigned      shadow_col;
    int unsigned      shadow_row;
    logic [FW_W-1:0]  shadow_width;
    logic [FH_W-1:0]  shadow_height;
    t_median_res      pending_medians [$];

    int  err_count;
    int  n_pixels;
    int  n_medians;
    int  n_frames;
    bit  idle_en;
    int  long_hold;
    int  rx_stall;
    int  quiet_cycles;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int eff_width();
        if (shadow_width == 0) return 1;
        if (shadow_width > BUF_DEPTH) return BUF_DEPTH;
        return int'(shadow_width);
    endfunction

    function automatic int eff_height();
        if (shadow_height == 0) return 1;
        if (shadow_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(shadow_height);
    endfunction

    // Median of the in-frame neighbours of (i,j), centered at window (wr,wc)
    function automatic void push_median(int i, int j, int wr, int wc, int w, int h,
                                        bit last);
        int          vals [9];
        int          cnt;
        int          k;
        int          x;
        t_median_res res;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (i + dr < 0 || i + dr >= h || j + dc < 0 || j + dc >= w) continue;
                if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
                x = win[wr + dr][wc + dc];
                k = cnt;
                while (k > 0 && vals[k - 1] > x) begin
                    vals[k] = vals[k - 1];
                    k--;
                end
                vals[k] = x;
                cnt++;
            end
        end
        res.med = 8'd0;
        if (cnt > 0) begin
            if (cnt % 2 == 0) res.med = 8'((vals[cnt / 2 - 1] + vals[cnt / 2]) >> 1);
            else res.med = 8'(vals[cnt / 2]);
        end
        res.row  = ROW_W'(i);
        res.col  = COL_W'(j);
        res.last = last;
        pending_medians.push_back(res);
    endfunction

    // Advance the shadow filter by one pixel
    function automatic void predict_pixel(logic [7:0] p);
        int          w;
        int          h;
        int unsigned c;
        int unsigned r;
        logic [7:0]  a;
        logic [7:0]  b;
        bit          lastc;
        bit          lastr;
        w = eff_width();
        h = eff_height();
        c = shadow_col;
        r = shadow_row;
        a = 8'd0;
        b = 8'd0;
        if (c < BUF_DEPTH) begin
            a = line_older[c];
            b = line_newer[c];
            line_older[c] = b;
            line_newer[c] = p;
        end
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = a;
        win[1][2] = b;
        win[2][2] = p;
        lastc = int'(c) + 1 >= w;
        lastr = int'(r) + 1 >= h;
        if (r >= 1 && c >= 1) push_median(r - 1, c - 1, 1, 1, w, h, 1'b0);
        if (r >= 1 && lastc)  push_median(r - 1, c, 1, 2, w, h, 1'b0);
        if (lastr && c >= 1)  push_median(r, c - 1, 2, 1, w, h, 1'b0);
        if (lastr && lastc)   push_median(r, c, 2, 2, w, h, 1'b1);
        if (lastc) begin
            shadow_col = 0;
            shadow_row = lastr ? 0 : r + 1;
            if (lastr) n_frames++;
        end else begin
            shadow_col = c + 1;
        end
    endfunction

    // Send one pixel; entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] p);
        int gap;
        gap = idle_en ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = p;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(p);
        n_pixels++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_medians.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(value);
        if (idx == REG_FRAME_WIDTH) shadow_width = FW_W'(value);
        else shadow_height = FH_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send pixels until the shadow frame counters wrap
    task automatic finish_frame();
        do send_pixel(rand_pixel());
        while (!(shadow_col == 0 && shadow_row == 0));
    endtask

    // Small frames covering corners, single rows and columns, even counts
    task automatic test_directed();
        logic [7:0] px9 [9] = '{8'h00, 8'hFF, 8'h80, 8'hFE, 8'hFF, 8'h01, 8'h7F, 8'h00, 8'hFF};
        idle_en = 1'b0;
        set_frame(3, 3);
        foreach (px9[k]) send_pixel(px9[k]);
        set_frame(2, 2);
        send_pixel(8'hFE); send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFE);
        set_frame(1, 1);
        send_pixel(8'hA5);
        set_frame(1, 3);
        send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h55);
        set_frame(2, 1);
        send_pixel(8'h01); send_pixel(8'hFF);
        wait_drained();
    endtask

    // Width and height shrink partway through a frame
    task automatic test_mid_frame_shrink();
        idle_en = 1'b1;
        set_frame(5, 4);
        repeat (8) send_pixel(rand_pixel());
        write_reg(REG_FRAME_WIDTH, 2);
        repeat (3) send_pixel(rand_pixel());
        write_reg(REG_FRAME_HEIGHT, 1);
        finish_frame();
        set_frame(4, 5);
        repeat (13) send_pixel(rand_pixel());
        write_reg(REG_FRAME_HEIGHT, 2);
        finish_frame();
        wait_drained();
    endtask

    // Random small frames with random idling on both sides
    task automatic test_random_frames();
        while (n_pixels < 260) begin
            idle_en = $urandom_range(0, 3) != 0;
            set_frame($urandom_range(1, 12), $urandom_range(1, 8));
            finish_frame();
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender streams, then sender pauses
    task automatic test_backpressure();
        idle_en = 1'b0;
        set_frame(10, 6);
        long_hold = 300;
        finish_frame();
        wait_drained();
    endtask

    // Out-of-range sizes; the first two frames are cut short by shrinking them mid-frame
    task automatic test_extremes();
        idle_en = 1'b0;
        set_frame(2047, 1);
        repeat (20) send_pixel(rand_pixel());
        write_reg(REG_FRAME_WIDTH, 2);
        finish_frame();
        set_frame(0, 8191);
        repeat (20) send_pixel(rand_pixel());
        write_reg(REG_FRAME_HEIGHT, 2);
        finish_frame();
        set_frame(0, 0);
        repeat (3) finish_frame();
        wait_drained();
    endtask

    // Receiver ready: long hold first, then per-transaction stalls
    always @(negedge i_clk) begin
        if (long_hold > 0) begin
            m_axis_tready <= 1'b0;
            long_hold--;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result check on each output transaction
    always @(posedge i_clk) begin
        t_median_res exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_medians++;
            rx_stall = idle_en ? $urandom_range(0, 8) : 0;
            if (pending_medians.size() == 0) begin
                report($sformatf("unexpected result tdata=%h", m_axis_tdata));
            end else begin
                exp_res = pending_medians.pop_front();
                if (m_axis_tdata[7:0] !== exp_res.med)
                    report($sformatf("median (%0d,%0d) got %0d exp %0d", exp_res.row,
                                     exp_res.col, m_axis_tdata[7:0], exp_res.med));
                if (m_axis_tdata[19:8] !== exp_res.row)
                    report($sformatf("row got %0d exp %0d", m_axis_tdata[19:8], exp_res.row));
                if (m_axis_tdata[29:20] !== exp_res.col)
                    report($sformatf("col got %0d exp %0d", m_axis_tdata[29:20], exp_res.col));
                if (m_axis_tlast !== exp_res.last)
                    report($sformatf("tlast (%0d,%0d) got %b exp %b", exp_res.row,
                                     exp_res.col, m_axis_tlast, exp_res.last));
            end
        end
    end

    // Watchdog on cycles without any transaction while work is outstanding
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (!s_axis_tvalid && pending_medians.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d medians outstanding", pending_medians.size());
                $display("median_filter_3x3_shrinking_edges_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        err_count     = 0;
        n_pixels      = 0;
        n_medians     = 0;
        n_frames      = 0;
        idle_en       = 1'b0;
        long_hold     = 0;
        rx_stall      = 0;
        quiet_cycles  = 0;
        shadow_col    = 0;
        shadow_row    = 0;
        shadow_width  = FW_W'(RST_WIDTH);
        shadow_height = FH_W'(RST_HEIGHT);
        foreach (line_older[k]) begin
            line_older[k] = 8'd0;
            line_newer[k] = 8'd0;
        end
        foreach (win[r, c]) win[r][c] = 8'd0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_mid_frame_shrink();
        test_random_frames();
        test_backpressure();
        test_extremes();
        wait_drained();

        $display("covered %0d pixels, %0d medians, %0d frames incl. edge, shrink and size limits",
                 n_pixels, n_medians, n_frames);
        $display("mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("median_filter_3x3_shrinking_edges_tb: clean");
        end else begin
            $display("median_filter_3x3_shrinking_edges_tb: errors");
        end
        $finish;
    end

endmodule
